[hdl/sfd_pkg.sv]
// Shared constants for the status frame deframer.
// Depends on nothing; imported by the deframer top level and its checker.
package sfd_pkg;

    localparam int PAYLOAD_MAX = 32;
    localparam int ADDR_W      = $clog2(PAYLOAD_MAX);
    localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);

    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 5;
    localparam int CFG_W       = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int STAT_LEN_W  = 6;
    localparam int OUT_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS_LEN  = 2'd2;

    localparam logic [BYTE_W-1:0]     START_BYTE_RST  = 8'hAA;
    localparam logic [BYTE_W-1:0]     STATUS_TYPE_RST = 8'h00;
    localparam logic [STAT_LEN_W-1:0] STATUS_LEN_RST  = 6'd16;

endpackage

[hdl/sfd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined after reset.
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/status_frame_deframer_unit.sv]
// Output: a released frame's first payload byte passes the drain phase, RAM
// read and output registers after its checksum byte transfers; the rest follow
// one per cycle when taken. Throughput: one received byte per cycle outside the
// drain phase; a released checksum byte holds off input during RAM read-out.
// Reset: parser hunts, config registers return to defaults, output is empty;
// payload RAM is not cleared. Depends on sfd_pkg and sfd_ram.
module status_frame_deframer_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,  // [7:0] rx_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [sfd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [7:0] status_byte, [12:8] byte_index
    output logic                              m_axis_tlast,  // last_byte
    input  logic                              cfg_we,
    input  logic [sfd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sfd_pkg::CFG_W-1:0]         cfg_data
);

    import sfd_pkg::*;

    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_DATA  = 3'd3;
    localparam logic [2:0] PH_SUM   = 3'd4;
    localparam logic [2:0] PH_DRAIN = 3'd5;

    logic [2:0]            phase_reg, phase_next;
    logic [BYTE_W-1:0]     frame_type_reg, frame_type_next;
    logic [LEN_W-1:0]      frame_len_reg, frame_len_next;
    logic [LEN_W-1:0]      byte_cnt_reg, byte_cnt_next;
    logic [BYTE_W-1:0]     xor_reg, xor_next;
    logic [BYTE_W-1:0]     start_byte_reg;
    logic [BYTE_W-1:0]     stat_type_reg;
    logic [STAT_LEN_W-1:0] stat_len_reg;
    logic [ADDR_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]     drain_last_reg, drain_last_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [ADDR_W-1:0]     rd_idx_pend_reg;
    logic                  rd_last_pend_reg;
    logic                  out_vld_reg, out_vld_next;
    logic [BYTE_W-1:0]     out_byte_reg;
    logic [IDX_W-1:0]      out_idx_reg;
    logic                  out_last_reg;

    logic [BYTE_W-1:0]     rx_byte;
    logic                  in_fire;
    logic                  ram_we;
    logic [BYTE_W-1:0]     ram_rdata;
    logic                  out_load;
    logic                  rd_issue;
    logic [LEN_W-1:0]      cnt_inc;
    logic                  frame_ok;

    assign rx_byte       = s_axis_tdata[BYTE_W-1:0];
    assign s_axis_tready = (phase_reg != PH_DRAIN);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign ram_we        = in_fire && (phase_reg == PH_DATA);
    assign cnt_inc       = byte_cnt_reg + LEN_W'(1);

    assign out_load = rd_vld_reg && (!out_vld_reg || m_axis_tready);
    assign rd_issue = (phase_reg == PH_DRAIN) && (!rd_vld_reg || out_load);

    assign frame_ok = (xor_reg == rx_byte) && (frame_type_reg == stat_type_reg)
                      && (STAT_LEN_W'(frame_len_reg) == stat_len_reg);

    sfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PAYLOAD_MAX)
    ) u_payload_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (byte_cnt_reg[ADDR_W-1:0]),
        .wdata (rx_byte),
        .re    (rd_issue),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        phase_next      = phase_reg;
        frame_type_next = frame_type_reg;
        frame_len_next  = frame_len_reg;
        byte_cnt_next   = byte_cnt_reg;
        xor_next        = xor_reg;
        rd_idx_next     = rd_idx_reg;
        drain_last_next = drain_last_reg;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == start_byte_reg)
                    begin
                        phase_next = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    frame_type_next = rx_byte;
                    phase_next      = PH_LEN;
                end
                PH_LEN:
                begin
                    if (rx_byte > BYTE_W'(PAYLOAD_MAX))
                    begin
                        phase_next      = PH_HUNT;
                        frame_type_next = '0;
                        frame_len_next  = '0;
                        byte_cnt_next   = '0;
                        xor_next        = '0;
                    end
                    else
                    begin
                        frame_len_next = rx_byte[LEN_W-1:0];
                        byte_cnt_next  = '0;
                        xor_next       = frame_type_reg ^ rx_byte;
                        phase_next     = (rx_byte == '0) ? PH_SUM : PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    byte_cnt_next = cnt_inc;
                    xor_next      = xor_reg ^ rx_byte;
                    if (cnt_inc >= frame_len_reg)
                    begin
                        phase_next = PH_SUM;
                    end
                end
                PH_SUM:
                begin
                    if (frame_ok && (frame_len_reg != '0))
                    begin
                        phase_next      = PH_DRAIN;
                        rd_idx_next     = '0;
                        drain_last_next = ADDR_W'(frame_len_reg - LEN_W'(1));
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                    end
                    frame_type_next = '0;
                    frame_len_next  = '0;
                    byte_cnt_next   = '0;
                    xor_next        = '0;
                end
                default:
                begin
                    phase_next      = PH_HUNT;
                    frame_type_next = '0;
                    frame_len_next  = '0;
                    byte_cnt_next   = '0;
                    xor_next        = '0;
                end
            endcase
        end
        else if (phase_reg > PH_DRAIN)
        begin
            phase_next = PH_HUNT;
        end

        if (rd_issue)
        begin
            rd_idx_next = rd_idx_reg + ADDR_W'(1);
            if (rd_idx_reg == drain_last_reg)
            begin
                phase_next = PH_HUNT;
            end
        end

        if (rd_issue)
        begin
            rd_vld_next = 1'b1;
        end
        else if (out_load)
        begin
            rd_vld_next = 1'b0;
        end
        else
        begin
            rd_vld_next = rd_vld_reg;
        end

        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            frame_type_reg <= '0;
            frame_len_reg  <= '0;
            byte_cnt_reg   <= '0;
            xor_reg        <= '0;
            start_byte_reg <= START_BYTE_RST;
            stat_type_reg  <= STATUS_TYPE_RST;
            stat_len_reg   <= STATUS_LEN_RST;
            rd_idx_reg     <= '0;
            drain_last_reg <= '0;
            rd_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            frame_type_reg <= frame_type_next;
            frame_len_reg  <= frame_len_next;
            byte_cnt_reg   <= byte_cnt_next;
            xor_reg        <= xor_next;
            rd_idx_reg     <= rd_idx_next;
            drain_last_reg <= drain_last_next;
            rd_vld_reg     <= rd_vld_next;
            out_vld_reg    <= out_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_START_BYTE:  start_byte_reg <= cfg_data;
                    REG_STATUS_TYPE: stat_type_reg  <= cfg_data;
                    REG_STATUS_LEN:  stat_len_reg   <= cfg_data[STAT_LEN_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload side, no reset
    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            rd_idx_pend_reg  <= rd_idx_reg;
            rd_last_pend_reg <= (rd_idx_reg == drain_last_reg);
        end
        if (out_load)
        begin
            out_byte_reg <= ram_rdata;
            out_idx_reg  <= IDX_W'(rd_idx_pend_reg);
            out_last_reg <= rd_last_pend_reg;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - BYTE_W - IDX_W){1'b0}}, out_idx_reg, out_byte_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

[hdl/sfd_checker.sv]
// Port-level checker for status_frame_deframer_unit, bound to the top level.
// Depends on sfd_pkg.
module sfd_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic [sfd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              m_axis_tlast
);

    import sfd_pkg::*;

    logic             out_fire;
    logic [IDX_W-1:0] exp_idx_reg;

    assign out_fire = m_axis_tvalid && m_axis_tready;

    // expected byte_index of the next output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
        end
        else if (out_fire)
        begin
            exp_idx_reg <= m_axis_tlast ? '0 : m_axis_tdata[BYTE_W +: IDX_W] + IDX_W'(1);
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata))
        else $error("input changed while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    a_idx_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> m_axis_tdata[BYTE_W +: IDX_W] == exp_idx_reg)
        else $error("byte_index out of sequence");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:BYTE_W+IDX_W] == '0)
        else $error("tdata padding not zero");

endmodule

bind status_frame_deframer_unit sfd_checker u_sfd_checker (.*);

[sim/tb_status_frame_deframer_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for status_frame_deframer_unit: random and directed byte frames
// are checked against a built-in frame parser model. Depends on sfd_pkg and the deframer RTL.
module tb_status_frame_deframer_unit;
    import sfd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_STALL  = 300;

    typedef enum logic [2:0] {P_HUNT, P_TYPE, P_LEN, P_DATA, P_SUM} parse_t;

    typedef struct packed {
        logic [7:0] data;
        logic [4:0] idx;
        logic       last;
    } status_rec_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_START_BYTE;
    logic [CFG_W-1:0]      cfg_data = '0;

    // model copy of the config registers
    logic [7:0]            cfg_start = START_BYTE_RST;
    logic [7:0]            cfg_type  = STATUS_TYPE_RST;
    logic [5:0]            cfg_len   = STATUS_LEN_RST;

    // model parser state
    parse_t                ph = P_HUNT;
    logic [7:0]            fr_type = '0;
    logic [5:0]            fr_len = '0;
    logic [5:0]            fr_cnt = '0;
    logic [7:0]            fr_sum = '0;
    logic [7:0]            payload_buf [PAYLOAD_MAX];

    logic [7:0]            rx_pend_q [$];
    status_rec_t           released_q [$];

    int                    err_cnt = 0;
    int                    cycle_cnt = 0;
    int                    stim_cnt = 0;
    int                    send_idle_pct = 0;
    int                    recv_stall_pct = 0;
    int                    hold_left = 0;
    bit                    long_stall_req = 1'b0;
    bit                    rx_took = 1'b0;

    status_frame_deframer_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic void clear_frame();
        ph      = P_HUNT;
        fr_type = '0;
        fr_len  = '0;
        fr_cnt  = '0;
        fr_sum  = '0;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        status_rec_t rec;
        case (ph)
            P_HUNT:
                if (b == cfg_start)
                    ph = P_TYPE;
            P_TYPE:
            begin
                fr_type = b;
                ph      = P_LEN;
            end
            P_LEN:
            begin
                if (b > PAYLOAD_MAX)
                    clear_frame();
                else
                begin
                    fr_len = b[5:0];
                    fr_cnt = '0;
                    fr_sum = fr_type ^ b;
                    ph     = (b == 8'd0) ? P_SUM : P_DATA;
                end
            end
            P_DATA:
            begin
                if (fr_cnt < PAYLOAD_MAX)
                    payload_buf[fr_cnt[4:0]] = b;
                fr_cnt = fr_cnt + 6'd1;
                fr_sum = fr_sum ^ b;
                if (fr_cnt >= fr_len)
                    ph = P_SUM;
            end
            P_SUM:
            begin
                if (fr_sum == b && fr_type == cfg_type && fr_len == cfg_len)
                begin
                    for (int i = 0; i < fr_len; i++)
                    begin
                        rec.data = payload_buf[i];
                        rec.idx  = i[4:0];
                        rec.last = (i + 1 == fr_len);
                        released_q.push_back(rec);
                    end
                end
                clear_frame();
            end
            default:
                clear_frame();
        endcase
    endfunction

    // checker and model update
    always @(posedge clk)
    begin
        status_rec_t want;
        rx_took = rst_n && s_axis_tvalid && s_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (released_q.size() == 0)
            begin
                $error("unexpected transfer: tdata %0h tlast %0b", m_axis_tdata, m_axis_tlast);
                err_cnt++;
            end
            else
            begin
                want = released_q.pop_front();
                if (m_axis_tdata[7:0] !== want.data)
                begin
                    $error("status_byte: expected %0h, got %0h", want.data, m_axis_tdata[7:0]);
                    err_cnt++;
                end
                if (m_axis_tdata[12:8] !== want.idx)
                begin
                    $error("byte_index: expected %0d, got %0d", want.idx, m_axis_tdata[12:8]);
                    err_cnt++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last_byte: expected %0b, got %0b", want.last, m_axis_tlast);
                    err_cnt++;
                end
            end
        end
        if (rx_took)
            deframe_byte(s_axis_tdata);
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || rx_took))
        begin
            if (rx_pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tdata  <= rx_pend_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output ready, with random stalls and an optional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (long_stall_req)
        begin
            long_stall_req = 1'b0;
            hold_left = LONG_STALL;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_START_BYTE:  cfg_start = val;
            REG_STATUS_TYPE: cfg_type  = val;
            REG_STATUS_LEN:  cfg_len   = val[5:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [7:0] sb, input logic [7:0] ty, input logic [5:0] len);
        write_reg(REG_START_BYTE, sb);
        write_reg(REG_STATUS_TYPE, ty);
        write_reg(REG_STATUS_LEN, {2'b00, len});
    endtask

    task automatic push_byte(input logic [7:0] b);
        rx_pend_q.push_back(b);
        stim_cnt++;
    endtask

    // start, type, length, payload, checksum; oversized length stops after the length byte
    task automatic queue_frame(input logic [7:0] sb, input logic [7:0] ty,
                               input logic [7:0] len, input bit bad_sum);
        logic [7:0] sum;
        logic [7:0] d;
        push_byte(sb);
        push_byte(ty);
        push_byte(len);
        sum = ty ^ len;
        if (len <= PAYLOAD_MAX)
        begin
            for (int i = 0; i < len; i++)
            begin
                d = 8'($urandom);
                push_byte(d);
                sum = sum ^ d;
            end
            if (bad_sum)
                sum = sum ^ (8'd1 << $urandom_range(7));
            push_byte(sum);
        end
    endtask

    task automatic queue_random_frame();
        int k;
        int n;
        k = $urandom_range(99);
        if (k < 65)
            queue_frame(cfg_start, cfg_type, {2'b00, cfg_len}, 1'b0);
        else if (k < 72)
            queue_frame(cfg_start, cfg_type, {2'b00, cfg_len}, 1'b1);
        else if (k < 79)
            queue_frame(cfg_start, cfg_type ^ 8'($urandom_range(1, 255)), {2'b00, cfg_len}, 1'b0);
        else if (k < 86)
            queue_frame(cfg_start, cfg_type, 8'($urandom_range(0, PAYLOAD_MAX)), 1'b0);
        else if (k < 92)
            queue_frame(cfg_start, 8'($urandom), 8'($urandom_range(PAYLOAD_MAX + 1, 255)), 1'b0);
        else
        begin
            n = $urandom_range(1, 3);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom));
        end
    endtask

    task automatic run_random(input int nbytes);
        int first;
        first = stim_cnt;
        while (stim_cnt - first < nbytes)
            queue_random_frame();
    endtask

    // all stimulus taken, all results seen, then an idle margin for the pipeline
    task automatic wait_drain();
        while (rx_pend_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (released_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, oversized and zero length, bad checksum, other type
        set_config(8'h00, 8'hFF, 6'd1);
        push_byte(8'h55);
        queue_frame(8'h00, 8'hFF, 8'd1, 1'b0);
        queue_frame(8'h00, 8'hFF, 8'd33, 1'b0);
        push_byte(8'hFF);
        queue_frame(8'h00, 8'hFF, 8'd0, 1'b0);
        queue_frame(8'h00, 8'hFF, 8'd1, 1'b1);
        queue_frame(8'h00, 8'hFE, 8'd1, 1'b0);
        wait_drain();

        // required length zero: matching empty frame gives nothing
        write_reg(REG_STATUS_LEN, 8'd0);
        queue_frame(8'h00, 8'hFF, 8'd0, 1'b0);
        wait_drain();

        set_config(START_BYTE_RST, STATUS_TYPE_RST, STATUS_LEN_RST);
        run_random(30);
        wait_drain();

        set_config(8'hFF, 8'hFF, 6'd32);
        send_idle_pct = 52;
        run_random(36);
        wait_drain();

        set_config(8'($urandom), 8'($urandom), 6'd1);
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        run_random(25);
        wait_drain();

        set_config(8'($urandom), 8'($urandom), 6'($urandom_range(1, 8)));
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        run_random(25);
        wait_drain();

        // back-pressure: output held off while matching frames keep coming
        set_config(8'h3C, 8'h81, 6'd8);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        long_stall_req = 1'b1;
        for (int i = 0; i < 4; i++)
            queue_frame(8'h3C, 8'h81, 8'd8, 1'b0);
        wait_drain();

        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
